// File: rtl/fsse_pkg.sv
// Shared constants for the frame store scroll engine.
// No dependencies; used by frame_store_scroll_engine.
`timescale 1ns / 1ps

package fsse_pkg;

  localparam logic [2:0] CMD_CLEAR     = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_COL_BITS  = 3'd3;
  localparam logic [2:0] CMD_SCROLL    = 3'd4;

  localparam logic [1:0] DIR_UP        = 2'd0;
  localparam logic [1:0] DIR_DOWN      = 2'd1;
  localparam logic [1:0] DIR_LEFT      = 2'd2;
  localparam logic [1:0] DIR_RIGHT     = 2'd3;

  // Number of column bits a write column bits command can place
  localparam int unsigned COL_BITS     = 8;

  // Data source for a delayed store write during a scroll
  typedef enum logic [1:0] {
    SRC_STORE,
    SRC_LINE,
    SRC_ZERO
  } src_sel_t;

endpackage

// File: rtl/frame_store_scroll_engine.sv
// Frame store scroll engine: ROWS x COLUMNS store of 8-bit pixels with
// clear, pixel access, column bit writes and one-place scrolls.
// Depends on fsse_pkg.
`timescale 1ns / 1ps

//  channel   ports                                         handshake
//  --------  --------------------------------------------  ----------------------
//  command   in_cmd in_col in_row in_data_value            start & !busy
//            in_direction in_wrap
//  result    out_read_value                                out_valid, one cycle
//
//  Write pixel, read pixel, unused codes and out-of-range column writes stay in
//  idle; the result strobes the next cycle and a new command may follow at once.
//  Write column bits fills min(8, ROWS) rows, clear zeroes all ROWS*COLUMNS entries;
//  a scroll moves every entry and with wrap first saves the row (up/down) or column
//  (left/right) that falls off; the single store port takes one entry per cycle.
//  After reset busy stays high while the store is zeroed.
//  The receiver cannot stall; each result is valid for exactly one cycle.

module frame_store_scroll_engine #(
  parameter int unsigned COLUMNS = 39,
  parameter int unsigned ROWS    = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [5:0] in_col,
  input  logic [3:0] in_row,
  input  logic [7:0] in_data_value,
  input  logic [1:0] in_direction,
  input  logic       in_wrap,
  output logic       out_valid,
  output logic [7:0] out_read_value
);

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned CW     = $clog2(COLUMNS);
  localparam int unsigned LINE   = (COLUMNS > ROWS) ? COLUMNS : ROWS;
  localparam int unsigned LW     = $clog2(LINE);
  localparam int unsigned KBITS  = (ROWS < fsse_pkg::COL_BITS) ? ROWS : fsse_pkg::COL_BITS;

  localparam logic [ADDR_W-1:0] A_COLS  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] A_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] A_LROW  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] A_LCOL  = ADDR_W'(COLUMNS - 1);
  localparam logic [RW-1:0]     R_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]     C_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]     K_LAST  = RW'(KBITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_COLBITS,
    S_SAVE,
    S_MOVE,
    S_DONE
  } state_t;

  state_t                state_r;
  logic                  report_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [RW-1:0]         r_r;
  logic [CW-1:0]         c_r;
  logic [7:0]            data_r;
  logic [1:0]            dir_r;
  logic                  wrap_r;
  logic                  out_valid_r;
  logic                  rd_hit_r;

  // Delayed write stage for the save and move walks
  logic                  pend_v_r;
  logic                  pend_line_r;
  fsse_pkg::src_sel_t    pend_sel_r;
  logic [ADDR_W-1:0]     pend_addr_r;
  logic [LW-1:0]         pend_lidx_r;

  logic [7:0]            store_mem [DEPTH];
  logic [7:0]            line_mem  [LINE];
  logic [7:0]            store_q;
  logic [7:0]            line_q;

  logic                  accept;
  logic                  in_col_ok;
  logic                  in_row_ok;
  logic [ADDR_W-1:0]     in_addr;
  logic                  vert;
  logic                  ascend;
  logic                  edge_hit;
  logic                  move_last;
  logic                  save_last;
  logic [ADDR_W-1:0]     src_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [LW-1:0]         line_ridx;
  logic                  st_we;
  logic [ADDR_W-1:0]     st_wa;
  logic [7:0]            st_wd;
  logic                  ln_we;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_col_ok = (7'(in_col) < 7'(COLUMNS));
  assign in_row_ok = (5'(in_row) < 5'(ROWS));
  assign in_addr   = ADDR_W'(32'(in_row) * COLUMNS + 32'(in_col));

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_hit_r ? store_q : 8'd0;

  assign vert   = (dir_r == fsse_pkg::DIR_UP) || (dir_r == fsse_pkg::DIR_DOWN);
  assign ascend = (dir_r == fsse_pkg::DIR_UP) || (dir_r == fsse_pkg::DIR_LEFT);

  // Edge entries take the saved line (or zero) instead of a store neighbor
  always_comb begin
    unique case (dir_r)
      fsse_pkg::DIR_UP: begin
        edge_hit = (r_r == R_LAST);
        src_addr = addr_r + A_COLS;
      end
      fsse_pkg::DIR_DOWN: begin
        edge_hit = (r_r == '0);
        src_addr = addr_r - A_COLS;
      end
      fsse_pkg::DIR_LEFT: begin
        edge_hit = (c_r == C_LAST);
        src_addr = addr_r + ADDR_W'(1);
      end
      default: begin
        edge_hit = (c_r == '0);
        src_addr = addr_r - ADDR_W'(1);
      end
    endcase
  end

  assign move_last = ascend ? ((r_r == R_LAST) && (c_r == C_LAST))
                            : ((r_r == '0) && (c_r == '0));
  assign save_last = vert ? (c_r == C_LAST) : (r_r == R_LAST);
  assign line_ridx = vert ? LW'(c_r) : LW'(r_r);

  always_comb begin
    if (state_r == S_MOVE) begin
      rd_addr = edge_hit ? addr_r : src_addr;
    end else if (state_r == S_SAVE) begin
      rd_addr = addr_r;
    end else begin
      rd_addr = in_row_ok && in_col_ok ? in_addr : '0;
    end
  end

  // Store write port
  always_comb begin
    st_we = 1'b0;
    st_wa = addr_r;
    st_wd = 8'd0;
    if (state_r == S_CLEAR) begin
      st_we = 1'b1;
    end else if (state_r == S_COLBITS) begin
      st_we = 1'b1;
      st_wd = {7'd0, data_r[0]};
    end else if (pend_v_r && !pend_line_r) begin
      st_we = 1'b1;
      st_wa = pend_addr_r;
      case (pend_sel_r)
        fsse_pkg::SRC_STORE: st_wd = store_q;
        fsse_pkg::SRC_LINE:  st_wd = line_q;
        default:             st_wd = 8'd0;
      endcase
    end else if (accept && (in_cmd == fsse_pkg::CMD_WRITE) && in_col_ok && in_row_ok) begin
      st_we = 1'b1;
      st_wa = in_addr;
      st_wd = in_data_value;
    end
  end

  assign ln_we = pend_v_r && pend_line_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    store_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      line_mem[pend_lidx_r] <= store_q;
    end
    line_q <= line_mem[line_ridx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      report_r    <= 1'b0;
      addr_r      <= '0;
      r_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
      rd_hit_r    <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            rd_hit_r <= (in_cmd == fsse_pkg::CMD_READ) && in_col_ok && in_row_ok;
            dir_r    <= in_direction;
            wrap_r   <= in_wrap;
            data_r   <= in_data_value;
            if (in_cmd == fsse_pkg::CMD_CLEAR) begin
              state_r  <= S_CLEAR;
              report_r <= 1'b1;
              addr_r   <= '0;
            end else if ((in_cmd == fsse_pkg::CMD_COL_BITS) && in_col_ok) begin
              state_r <= S_COLBITS;
              r_r     <= '0;
              addr_r  <= ADDR_W'(in_col);
            end else if (in_cmd == fsse_pkg::CMD_SCROLL) begin
              if (in_wrap) begin
                // Save the line that falls off before it is overwritten
                state_r <= S_SAVE;
                unique case (in_direction)
                  fsse_pkg::DIR_UP: begin
                    r_r <= '0;     c_r <= '0;     addr_r <= '0;
                  end
                  fsse_pkg::DIR_DOWN: begin
                    r_r <= R_LAST; c_r <= '0;     addr_r <= A_LROW;
                  end
                  fsse_pkg::DIR_LEFT: begin
                    r_r <= '0;     c_r <= '0;     addr_r <= '0;
                  end
                  default: begin
                    r_r <= '0;     c_r <= C_LAST; addr_r <= A_LCOL;
                  end
                endcase
              end else begin
                state_r <= S_MOVE;
                if ((in_direction == fsse_pkg::DIR_UP) ||
                    (in_direction == fsse_pkg::DIR_LEFT)) begin
                  r_r <= '0;     c_r <= '0;     addr_r <= '0;
                end else begin
                  r_r <= R_LAST; c_r <= C_LAST; addr_r <= A_LAST;
                end
              end
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_CLEAR: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (addr_r == A_LAST) begin
            state_r     <= S_IDLE;
            out_valid_r <= report_r;
            report_r    <= 1'b0;
          end
        end
        S_COLBITS: begin
          addr_r <= addr_r + A_COLS;
          r_r    <= r_r + RW'(1);
          data_r <= {1'b0, data_r[7:1]};
          if (r_r == K_LAST) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_SAVE: begin
          pend_v_r    <= 1'b1;
          pend_line_r <= 1'b1;
          pend_lidx_r <= line_ridx;
          if (save_last) begin
            state_r <= S_MOVE;
            if (ascend) begin
              r_r <= '0;     c_r <= '0;     addr_r <= '0;
            end else begin
              r_r <= R_LAST; c_r <= C_LAST; addr_r <= A_LAST;
            end
          end else if (vert) begin
            c_r    <= c_r + CW'(1);
            addr_r <= addr_r + ADDR_W'(1);
          end else begin
            r_r    <= r_r + RW'(1);
            addr_r <= addr_r + A_COLS;
          end
        end
        S_MOVE: begin
          pend_v_r    <= 1'b1;
          pend_line_r <= 1'b0;
          pend_addr_r <= addr_r;
          if (!edge_hit) begin
            pend_sel_r <= fsse_pkg::SRC_STORE;
          end else if (wrap_r) begin
            pend_sel_r <= fsse_pkg::SRC_LINE;
          end else begin
            pend_sel_r <= fsse_pkg::SRC_ZERO;
          end
          if (move_last) begin
            state_r <= S_DONE;
          end else if (ascend) begin
            addr_r <= addr_r + ADDR_W'(1);
            if (c_r == C_LAST) begin
              c_r <= '0;
              r_r <= r_r + RW'(1);
            end else begin
              c_r <= c_r + CW'(1);
            end
          end else begin
            addr_r <= addr_r - ADDR_W'(1);
            if (c_r == '0) begin
              c_r <= C_LAST;
              r_r <= r_r - RW'(1);
            end else begin
              c_r <= c_r - CW'(1);
            end
          end
        end
        S_DONE: begin
          // Last delayed write lands this cycle
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/tb_frame_store_scroll_engine.sv
// Self-checking testbench for frame_store_scroll_engine: directed table, then random
// commands checked against a shadow copy of the pixel store.
// Depends on fsse_pkg and rtl/frame_store_scroll_engine.sv.
`timescale 1ns / 1ps

module tb_frame_store_scroll_engine;

  localparam int COLS = 39;
  localparam int ROWS = 9;
  localparam int N_ITEMS = 1300;
  localparam int MAX_GAP = 13;
  localparam int DRAIN_CYCLES = 40;
  // slowest command: full scroll with wrap
  localparam int SLOWEST_CMD = ROWS * COLS + 1 + COLS;
  localparam int CYCLE_LIMIT = 3 * (N_ITEMS * (SLOWEST_CMD + MAX_GAP + 2) + ROWS * COLS + 100);

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] col;
    logic [3:0] row;
    logic [7:0] value;
    logic [1:0] dir;
    logic       wrap;
    logic       typed;
    logic [7:0] want;
  } step_t;

  localparam int N_DIRECTED = 26;

  // typed rows carry the read value that is obvious by inspection
  step_t directed_steps [N_DIRECTED] = '{
    '{fsse_pkg::CMD_READ,     6'd0,  4'd0,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd38, 4'd8,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'h00},
    '{fsse_pkg::CMD_WRITE,    6'd38, 4'd8,  8'hff, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd38, 4'd8,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'hff},
    '{fsse_pkg::CMD_WRITE,    6'd0,  4'd0,  8'h01, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_WRITE,    6'd63, 4'd15, 8'haa, fsse_pkg::DIR_RIGHT, 1'b1, 1'b0, 8'h00},
    '{fsse_pkg::CMD_WRITE,    6'd39, 4'd0,  8'h55, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_WRITE,    6'd0,  4'd9,  8'h55, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd63, 4'd15, 8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd39, 4'd0,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd0,  4'd9,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b1, 8'h00},
    '{fsse_pkg::CMD_COL_BITS, 6'd38, 4'd0,  8'ha5, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_COL_BITS, 6'd0,  4'd0,  8'hff, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_COL_BITS, 6'd39, 4'd0,  8'hff, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_UP,    1'b1, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_LEFT,  1'b1, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_DOWN,  1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_RIGHT, 1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd0,  4'd0,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_DOWN,  1'b1, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_RIGHT, 1'b1, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_SCROLL,   6'd0,  4'd0,  8'h00, fsse_pkg::DIR_LEFT,  1'b0, 1'b0, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd37, 4'd7,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00},
    '{CMD_UNUSED_LAST,        6'd38, 4'd8,  8'hff, fsse_pkg::DIR_RIGHT, 1'b1, 1'b1, 8'h00},
    '{fsse_pkg::CMD_READ,     6'd38, 4'd8,  8'h00, fsse_pkg::DIR_UP,    1'b0, 1'b0, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_cmd = fsse_pkg::CMD_CLEAR;
  logic [5:0] in_col = '0;
  logic [3:0] in_row = '0;
  logic [7:0] in_data_value = '0;
  logic [1:0] in_direction = fsse_pkg::DIR_UP;
  logic       in_wrap = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_read_value;

  logic [7:0] shadow_px [ROWS][COLS];
  logic [7:0] pending_reads [$];
  logic [7:0] oldest_read;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned n_reads = 0;
  int unsigned n_scrolls = 0;
  int unsigned n_clears = 0;
  int unsigned n_col_bits = 0;

  frame_store_scroll_engine #(.COLUMNS(COLS), .ROWS(ROWS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_data_value (in_data_value),
    .in_direction  (in_direction),
    .in_wrap       (in_wrap),
    .out_valid     (out_valid),
    .out_read_value(out_read_value)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Apply one command to the shadow store and return the read value it yields.
  function automatic logic [7:0] apply_to_shadow(input logic [2:0] cmd, input logic [5:0] col,
                                                 input logic [3:0] row, input logic [7:0] value,
                                                 input logic [1:0] dir, input logic wrap);
    logic [7:0] result;
    logic [7:0] lost;
    logic [7:0] edge_line [COLS];
    result = 8'h00;
    case (cmd)
      fsse_pkg::CMD_CLEAR: begin
        for (int r = 0; r < ROWS; r++)
          for (int c = 0; c < COLS; c++) shadow_px[r][c] = 8'h00;
      end
      fsse_pkg::CMD_WRITE: begin
        if (int'(col) < COLS && int'(row) < ROWS) shadow_px[row][col] = value;
      end
      fsse_pkg::CMD_READ: begin
        if (int'(col) < COLS && int'(row) < ROWS) result = shadow_px[row][col];
      end
      fsse_pkg::CMD_COL_BITS: begin
        if (int'(col) < COLS)
          for (int k = 0; k < int'(fsse_pkg::COL_BITS); k++)
            if (k < ROWS) shadow_px[k][col] = {7'b0, value[k]};
      end
      fsse_pkg::CMD_SCROLL: begin
        case (dir)
          fsse_pkg::DIR_UP: begin
            for (int c = 0; c < COLS; c++) edge_line[c] = wrap ? shadow_px[0][c] : 8'h00;
            for (int r = 0; r < ROWS - 1; r++)
              for (int c = 0; c < COLS; c++) shadow_px[r][c] = shadow_px[r + 1][c];
            for (int c = 0; c < COLS; c++) shadow_px[ROWS - 1][c] = edge_line[c];
          end
          fsse_pkg::DIR_DOWN: begin
            for (int c = 0; c < COLS; c++)
              edge_line[c] = wrap ? shadow_px[ROWS - 1][c] : 8'h00;
            for (int r = ROWS - 1; r > 0; r--)
              for (int c = 0; c < COLS; c++) shadow_px[r][c] = shadow_px[r - 1][c];
            for (int c = 0; c < COLS; c++) shadow_px[0][c] = edge_line[c];
          end
          fsse_pkg::DIR_LEFT: begin
            for (int r = 0; r < ROWS; r++) begin
              lost = shadow_px[r][0];
              for (int c = 0; c < COLS - 1; c++) shadow_px[r][c] = shadow_px[r][c + 1];
              shadow_px[r][COLS - 1] = wrap ? lost : 8'h00;
            end
          end
          default: begin
            for (int r = 0; r < ROWS; r++) begin
              lost = shadow_px[r][COLS - 1];
              for (int c = COLS - 1; c > 0; c--) shadow_px[r][c] = shadow_px[r][c - 1];
              shadow_px[r][0] = wrap ? lost : 8'h00;
            end
          end
        endcase
      end
      default: ;
    endcase
    return result;
  endfunction

  // Bursts of back-to-back commands alternate with randomly spaced ones.
  function automatic int unsigned draw_gap(input int idx);
    return ((idx / 48) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic issue_command(input step_t s, input int unsigned gap);
    logic [7:0] predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= s.cmd;
    in_col        <= s.col;
    in_row        <= s.row;
    in_data_value <= s.value;
    in_direction  <= s.dir;
    in_wrap       <= s.wrap;
    // hold the transaction until the engine takes it
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = apply_to_shadow(s.cmd, s.col, s.row, s.value, s.dir, s.wrap);
    pending_reads.push_back(s.typed ? s.want : predicted);
    case (s.cmd)
      fsse_pkg::CMD_READ:     n_reads++;
      fsse_pkg::CMD_SCROLL:   n_scrolls++;
      fsse_pkg::CMD_CLEAR:    n_clears++;
      fsse_pkg::CMD_COL_BITS: n_col_bits++;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("result with no transaction pending", out_read_value, 8'h00);
      end else begin
        oldest_read = pending_reads.pop_front();
        n_checked++;
        if (out_read_value !== oldest_read)
          report_mismatch("out_read_value", out_read_value, oldest_read);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reads.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    step_t s;
    int unsigned pick;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++) shadow_px[r][c] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) issue_command(directed_steps[i], draw_gap(i));

    for (int i = N_DIRECTED; i < N_ITEMS; i++) begin
      s.typed = 1'b0;
      s.want  = 8'h00;
      s.value = 8'($urandom_range(0, 255));
      s.dir   = 2'($urandom_range(0, 3));
      s.wrap  = 1'($urandom_range(0, 1));
      // mostly legal coordinates, some anywhere in the field range
      s.col = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, COLS - 1)
                                             : $urandom_range(0, 63));
      s.row = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, ROWS - 1)
                                             : $urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 2)       s.cmd = fsse_pkg::CMD_CLEAR;
      else if (pick < 36) s.cmd = fsse_pkg::CMD_WRITE;
      else if (pick < 72) s.cmd = fsse_pkg::CMD_READ;
      else if (pick < 82) s.cmd = fsse_pkg::CMD_COL_BITS;
      else if (pick < 96) s.cmd = fsse_pkg::CMD_SCROLL;
      else                s.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      issue_command(s, draw_gap(i));
    end
    start <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d reads, %0d scrolls, %0d column writes, %0d clears",
             N_ITEMS, n_reads, n_scrolls, n_col_bits, n_clears);
    $display("Checked %0d results in %0d cycles, %0d mismatches", n_checked, cycle_count,
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
